/* hdl/tss_pkg.sv */
`default_nettype none

package tss_pkg;

   // Field widths fixed by the interface
   localparam int IDX_W  = 4;
   localparam int TIME_W = 16;

   // Stored time that marks an empty slot
   localparam logic [TIME_W-1:0] EMPTY_TIME = 16'hFFFF;

   // Item kinds carried on req_tuser
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_TIME  = 1'b1;

   // run_mode codes
   localparam logic MODE_BEST = 1'b0;
   localparam logic MODE_SEQ  = 1'b1;

   // Table access from the sequencer
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [TIME_W-1:0] wr_data;
      logic [IDX_W-1:0]  rd_addr;
   } mem_req_type;

   // Finished selection offered to the output register
   typedef struct packed {
      logic             vld;
      logic [IDX_W-1:0] slot;
   } result_type;

endpackage

`default_nettype wire

/* hdl/tss_ram.sv */
`default_nettype none

module tss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 10
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* hdl/tss_ctrl.sv */
`default_nettype none

module tss_ctrl
   import tss_pkg::*;
#(
   parameter int SLOT_COUNT = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic              action,
   input  wire logic [IDX_W-1:0]  slot_number,
   input  wire logic [TIME_W-1:0] slot_time,
   input  wire logic [TIME_W-1:0] now_time,
   input  wire logic              run_mode,
   input  wire logic [TIME_W-1:0] rd_time,
   output mem_req_type            mem_req,
   output result_type             result,
   input  wire logic              res_taken
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_LAST = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_SEQA = 3'd4;
   localparam logic [2:0] ST_SEQB = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   localparam logic [IDX_W-1:0] TAIL_SLOT = IDX_W'(SLOT_COUNT - 1);

   logic [2:0]        state_ff, state_in;
   logic              first_ff, first_in;
   logic [IDX_W-1:0]  chosen_ff, chosen_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  lag_idx_ff, lag_idx_in;
   logic              lag_vld_ff, lag_vld_in;
   logic [IDX_W-1:0]  nxt_ff, nxt_in;
   logic              skip_ff, skip_in;
   logic              found_ff, found_in;
   logic [TIME_W-1:0] diff_ff, diff_in;
   logic [IDX_W-1:0]  pick_ff, pick_in;
   logic              any_ff, any_in;
   logic [TIME_W-1:0] top_ff, top_in;
   logic [IDX_W-1:0]  top_pick_ff, top_pick_in;

   logic              accept;
   logic              slot_ok;
   logic              rd_empty;
   logic [TIME_W-1:0] rd_diff;
   logic              upd_en;
   logic [IDX_W-1:0]  chosen_next;
   logic [IDX_W-1:0]  nxt_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_ok    = ({1'b0, slot_number} < (IDX_W + 1)'(SLOT_COUNT));

   // Write transfers to a slot in range go straight into the table
   always_comb begin
      mem_req.wr_en   = accept && (action == ACT_WRITE) && slot_ok;
      mem_req.wr_addr = slot_number;
      mem_req.wr_data = slot_time;
      mem_req.rd_addr = (state_ff == ST_SEQA) ? nxt_ff : idx_ff;
   end

   assign result.vld  = (state_ff == ST_DONE);
   assign result.slot = chosen_ff;

   assign rd_empty    = (rd_time == EMPTY_TIME);
   assign rd_diff     = now_ff - rd_time;
   assign upd_en      = ((state_ff == ST_SCAN) || (state_ff == ST_LAST)) && lag_vld_ff;
   assign chosen_next = (chosen_ff == TAIL_SLOT) ? '0 : chosen_ff + 1'b1;
   assign nxt_next    = (nxt_ff == TAIL_SLOT) ? '0 : nxt_ff + 1'b1;

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      first_in    = first_ff;
      chosen_in   = chosen_ff;
      now_in      = now_ff;
      idx_in      = idx_ff;
      lag_idx_in  = lag_idx_ff;
      lag_vld_in  = lag_vld_ff;
      nxt_in      = nxt_ff;
      skip_in     = skip_ff;
      found_in    = found_ff;
      diff_in     = diff_ff;
      pick_in     = pick_ff;
      any_in      = any_ff;
      top_in      = top_ff;
      top_pick_in = top_pick_ff;

      // Fold the slot read last cycle into both running selections
      if (upd_en && !rd_empty) begin
         if ((rd_time <= now_ff) && (!found_ff || (rd_diff < diff_ff))) begin
            found_in = 1'b1;
            diff_in  = rd_diff;
            pick_in  = lag_idx_ff;
         end
         if (!any_ff || (rd_time > top_ff)) begin
            any_in      = 1'b1;
            top_in      = rd_time;
            top_pick_in = lag_idx_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (action == ACT_TIME)) begin
               now_in     = now_time;
               idx_in     = '0;
               lag_vld_in = 1'b0;
               found_in   = 1'b0;
               any_in     = 1'b0;
               skip_in    = 1'b0;
               nxt_in     = chosen_next;
               if (first_ff || (run_mode == MODE_BEST)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_SEQA;
               end
            end
         end
         ST_SCAN: begin
            lag_idx_in = idx_ff;
            lag_vld_in = 1'b1;
            if (idx_ff == TAIL_SLOT) begin
               state_in = ST_LAST;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_LAST: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            first_in = 1'b0;
            if (found_ff) begin
               chosen_in = pick_ff;
            end else if (any_ff) begin
               chosen_in = top_pick_ff;
            end else begin
               chosen_in = '0;
            end
            state_in = ST_DONE;
         end
         ST_SEQA: begin
            state_in = ST_SEQB;
         end
         ST_SEQB: begin
            // Skip one empty slot, then advance only on an exact time match
            if (rd_empty && !skip_ff) begin
               skip_in  = 1'b1;
               nxt_in   = nxt_next;
               state_in = ST_SEQA;
            end else begin
               if (now_ff == rd_time) begin
                  chosen_in = nxt_ff;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_taken) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         first_ff  <= 1'b1;
         chosen_ff <= '0;
      end else begin
         state_ff  <= state_in;
         first_ff  <= first_in;
         chosen_ff <= chosen_in;
      end
      now_ff      <= now_in;
      idx_ff      <= idx_in;
      lag_idx_ff  <= lag_idx_in;
      lag_vld_ff  <= lag_vld_in;
      nxt_ff      <= nxt_in;
      skip_ff     <= skip_in;
      found_ff    <= found_in;
      diff_ff     <= diff_in;
      pick_ff     <= pick_in;
      any_ff      <= any_in;
      top_ff      <= top_in;
      top_pick_ff <= top_pick_in;
   end

endmodule

`default_nettype wire

/* hdl/time_slot_selector_core.sv */
`default_nettype none

// Write item: gives no result; next item may follow at once.
// Time item, best match (first item after reset or run_mode 0): one table read per
// slot through the single read port.
// Time item, sequential mode: reads the next slot, and the one after it when that slot is empty.
// The result register holds an answer while the next item is taken.
// Synchronous reset empties every slot, selects slot 0 and arms the first-item search.

module time_slot_selector_core
   import tss_pkg::*;
#(
   parameter int SLOT_COUNT = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: slot_number[3:0], slot_time[19:4], now_time[35:20], zero pad
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,
   // req_tuser: action[0]
   input  wire logic        req_tuser,
   // rsp_tdata: active_slot[3:0], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_wdata
);

   localparam int AW = $clog2(SLOT_COUNT);

   logic [SLOT_COUNT-1:0] valid_ff, valid_in;
   logic                  rd_vld_ff;
   logic                  run_mode_ff;
   logic                  rsp_vld_ff;
   logic [IDX_W-1:0]      rsp_slot_ff;
   logic [TIME_W-1:0]     ram_q;
   logic [TIME_W-1:0]     rd_time;
   logic                  res_taken;
   mem_req_type           mem_req;
   result_type            result;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'b0000, rsp_slot_ff};

   // Load the result register when it is empty or draining this cycle
   assign res_taken = result.vld && (!rsp_vld_ff || rsp_tready);

   // Slots never written read as empty
   assign rd_time = rd_vld_ff ? ram_q : EMPTY_TIME;

   always_comb begin
      valid_in = valid_ff;
      if (mem_req.wr_en) begin
         valid_in[mem_req.wr_addr[AW-1:0]] = 1'b1;
      end
   end

   tss_ram #(
      .WIDTH (TIME_W),
      .DEPTH (SLOT_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr[AW-1:0]),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr[AW-1:0]),
      .rd_data (ram_q)
   );

   tss_ctrl #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .action       (req_tuser),
      .slot_number  (req_tdata[3:0]),
      .slot_time    (req_tdata[19:4]),
      .now_time     (req_tdata[35:20]),
      .run_mode     (run_mode_ff),
      .rd_time      (rd_time),
      .mem_req      (mem_req),
      .result       (result),
      .res_taken    (res_taken)
   );

   // Hold valid bits, run mode and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         run_mode_ff <= MODE_BEST;
         rsp_vld_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (csr_valid && csr_ready) begin
            run_mode_ff <= csr_wdata;
         end
         if (res_taken) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
      rd_vld_ff <= valid_ff[mem_req.rd_addr[AW-1:0]];
      if (res_taken) begin
         rsp_slot_ff <= result.slot;
      end
   end

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench
   import tss_pkg::*;
();

   localparam int SLOTS = 10;
   localparam int SETTLE_CYCLES = 20;

   typedef enum logic [1:0] {ROW_WRITE, ROW_TIME, ROW_MODE} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [IDX_W-1:0]  slot;
      logic [TIME_W-1:0] stime;
      logic [TIME_W-1:0] now;
      logic              mode;
      bit                known;
      logic [IDX_W-1:0]  want;
   } stim_row_type;

   localparam int PLAN_LEN = 25;

   // Directed walk: sequential stepping, skips, wraps, then best-match corners
   stim_row_type plan [PLAN_LEN] = '{
      '{ROW_MODE,  4'd0,  16'h0000, 16'h0000, MODE_SEQ,  1'b0, 4'd0},
      '{ROW_TIME,  4'd0,  16'h0000, 16'h0000, MODE_SEQ,  1'b1, 4'd0},
      '{ROW_WRITE, 4'd0,  16'd10,   16'h0000, MODE_SEQ,  1'b0, 4'd0},
      '{ROW_WRITE, 4'd1,  16'd20,   16'h0000, MODE_SEQ,  1'b0, 4'd0},
      '{ROW_WRITE, 4'd3,  16'd40,   16'h0000, MODE_SEQ,  1'b0, 4'd0},
      '{ROW_WRITE, 4'd15, 16'd7,    16'hFFFF, MODE_SEQ,  1'b0, 4'd0},
      '{ROW_TIME,  4'd0,  16'h0000, 16'd20,   MODE_SEQ,  1'b0, 4'd0},
      '{ROW_TIME,  4'd0,  16'h0000, 16'd40,   MODE_SEQ,  1'b0, 4'd0},
      '{ROW_TIME,  4'd0,  16'h0000, 16'd99,   MODE_SEQ,  1'b0, 4'd0},
      '{ROW_TIME,  4'd0,  16'h0000, 16'hFFFF, MODE_SEQ,  1'b0, 4'd0},
      '{ROW_WRITE, 4'd9,  16'd90,   16'h0000, MODE_SEQ,  1'b0, 4'd0},
      '{ROW_TIME,  4'd0,  16'h0000, 16'hFFFF, MODE_SEQ,  1'b0, 4'd0},
      '{ROW_TIME,  4'd0,  16'h0000, 16'd90,   MODE_SEQ,  1'b0, 4'd0},
      '{ROW_TIME,  4'd0,  16'h0000, 16'd10,   MODE_SEQ,  1'b0, 4'd0},
      '{ROW_WRITE, 4'd9,  16'hFFFF, 16'h0000, MODE_SEQ,  1'b0, 4'd0},
      '{ROW_WRITE, 4'd8,  16'd80,   16'h0000, MODE_SEQ,  1'b0, 4'd0},
      '{ROW_MODE,  4'd0,  16'h0000, 16'h0000, MODE_BEST, 1'b0, 4'd0},
      '{ROW_TIME,  4'd0,  16'h0000, 16'd80,   MODE_BEST, 1'b0, 4'd0},
      '{ROW_MODE,  4'd0,  16'h0000, 16'h0000, MODE_SEQ,  1'b0, 4'd0},
      '{ROW_TIME,  4'd0,  16'h0000, 16'd10,   MODE_SEQ,  1'b0, 4'd0},
      '{ROW_MODE,  4'd0,  16'h0000, 16'h0000, MODE_BEST, 1'b0, 4'd0},
      '{ROW_TIME,  4'd0,  16'h0000, 16'h0000, MODE_BEST, 1'b0, 4'd0},
      '{ROW_WRITE, 4'd10, 16'hFFFE, 16'h0000, MODE_BEST, 1'b0, 4'd0},
      '{ROW_WRITE, 4'd5,  16'hFFFE, 16'h0000, MODE_BEST, 1'b0, 4'd0},
      '{ROW_TIME,  4'd0,  16'h0000, 16'hFFFF, MODE_BEST, 1'b0, 4'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = ACT_WRITE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_wdata = MODE_BEST;

   // Predictor state
   logic [TIME_W-1:0] sched_times [SLOTS];
   logic [IDX_W-1:0]  sel_slot;
   bit                first_lookup;
   logic              mode_reg;

   logic [IDX_W-1:0] expected_slots [$];
   int  fault_count = 0;
   int  req_gap_odds = 0;
   int  stall_odds = 0;
   bit  calm = 1'b0;
   int  stall_left = 0;

   time_slot_selector_core #(.SLOT_COUNT(SLOTS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Closest valid slot at or before now; else the latest valid slot; else slot 0
   function automatic logic [IDX_W-1:0] closest_slot(input logic [TIME_W-1:0] now);
      logic [IDX_W-1:0]  pick;
      logic [TIME_W-1:0] gap;
      logic [TIME_W-1:0] best_gap;
      logic [TIME_W-1:0] top;
      bit                found;
      bit                any;
      pick = '0;
      best_gap = '0;
      top = '0;
      found = 1'b0;
      any = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (sched_times[i] != EMPTY_TIME && sched_times[i] <= now) begin
            gap = now - sched_times[i];
            if (!found || gap < best_gap) begin
               found = 1'b1;
               best_gap = gap;
               pick = IDX_W'(i);
            end
         end
      end
      if (!found) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (sched_times[i] != EMPTY_TIME && (!any || sched_times[i] > top)) begin
               any = 1'b1;
               top = sched_times[i];
               pick = IDX_W'(i);
            end
         end
      end
      return pick;
   endfunction

   // Slot the sequencer looks at next: skip one empty slot, wrap to 0
   function automatic int upcoming_slot();
      int nxt;
      nxt = (int'(sel_slot) + 1) % SLOTS;
      if (sched_times[nxt] == EMPTY_TIME) nxt++;
      if (nxt >= SLOTS) nxt = 0;
      return nxt;
   endfunction

   function automatic logic [TIME_W-1:0] random_stamp();
      case ($urandom_range(0, 9))
         0, 1: return EMPTY_TIME;
         2: return 16'h0000;
         3: return 16'hFFFE;
         4, 5, 6: return 16'($urandom_range(0, 15) * 64);
         default: return 16'($urandom);
      endcase
   endfunction

   // Drive one item, wait for its transfer, then update the predictor
   task automatic issue_item(input logic act, input logic [IDX_W-1:0] slot,
                             input logic [TIME_W-1:0] stime,
                             input logic [TIME_W-1:0] now,
                             input bit known, input logic [IDX_W-1:0] want);
      if (req_gap_odds != 0 && $urandom_range(1, req_gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {4'b0000, now, stime, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (act == ACT_WRITE) begin
         if (slot < SLOTS) sched_times[slot] = stime;
      end else begin
         if (first_lookup || mode_reg == MODE_BEST) begin
            first_lookup = 1'b0;
            sel_slot = closest_slot(now);
         end else if (now == sched_times[upcoming_slot()]) begin
            sel_slot = IDX_W'(upcoming_slot());
         end
         expected_slots.push_back(known ? want : sel_slot);
      end
   endtask

   // Change mode only with the block drained and settled
   task automatic set_mode(input logic mode);
      req_tvalid <= 1'b0;
      while (expected_slots.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      mode_reg = mode;
   endtask

   task automatic random_item();
      logic [IDX_W-1:0]  slot;
      logic [TIME_W-1:0] now;
      if ($urandom_range(0, 99) < 35) begin
         slot = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(SLOTS, 15))
                                            : IDX_W'($urandom_range(0, SLOTS - 1));
         issue_item(ACT_WRITE, slot, random_stamp(), 16'($urandom), 1'b0, '0);
      end else begin
         // Mostly hit the next slot's time in sequential mode so the walk advances
         if (mode_reg == MODE_SEQ && !first_lookup && $urandom_range(0, 99) < 70)
            now = sched_times[upcoming_slot()];
         else if ($urandom_range(0, 3) == 0)
            now = sched_times[$urandom_range(0, SLOTS - 1)];
         else
            now = random_stamp();
         issue_item(ACT_TIME, IDX_W'($urandom), 16'($urandom), now, 1'b0, '0);
      end
   endtask

   // Receiver side: random stall bursts, none once the run goes calm
   always @(posedge clock) begin
      if (calm) begin
         stall_left = 0;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         stall_left = $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each result transfer with the oldest expected slot
   always @(posedge clock) begin
      logic [IDX_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_slots.size() == 0) begin
            $display("%0t ns: result %h arrived, expected none", $time, rsp_tdata);
            fault_count++;
         end else begin
            want = expected_slots.pop_front();
            if (rsp_tdata !== {4'b0000, want}) begin
               $display("%0t ns: active_slot expected %0d, got %h", $time, want, rsp_tdata);
               fault_count++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) sched_times[i] = EMPTY_TIME;
      sel_slot = '0;
      first_lookup = 1'b1;
      mode_reg = MODE_BEST;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      req_gap_odds = 3;
      stall_odds = 4;
      foreach (plan[i]) begin
         case (plan[i].kind)
            ROW_MODE:  set_mode(plan[i].mode);
            ROW_WRITE: issue_item(ACT_WRITE, plan[i].slot, plan[i].stime, plan[i].now,
                                  1'b0, '0);
            default:   issue_item(ACT_TIME, plan[i].slot, plan[i].stime, plan[i].now,
                                  plan[i].known, plan[i].want);
         endcase
      end

      // Random phases, alternating mode; the last one runs without idling
      for (int p = 0; p < 6; p++) begin
         set_mode((p % 2 == 0) ? MODE_SEQ : MODE_BEST);
         if (p == 5) begin
            calm = 1'b1;
            req_gap_odds = 0;
            stall_odds = 0;
         end else begin
            req_gap_odds = ($urandom_range(0, 2) == 0) ? 0 : 4;
            stall_odds = ($urandom_range(0, 2) == 0) ? 0 : 4;
         end
         repeat (80) random_item();
      end

      req_tvalid <= 1'b0;
      while (expected_slots.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Hard stop in case the handshake hangs
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
